>>> src/resc_pkg.sv
// Shared types, command codes and register defaults for the robot enable and
// emergency-stop controller. No dependencies; used by every module in src.
`default_nettype none

package resc_pkg;

    localparam int unsigned CmdW = 4;
    localparam int unsigned TimeW = 32;
    localparam int unsigned SeqW = 16;
    localparam int unsigned StatusW = 6;
    localparam int unsigned HookW = 9;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 32;
    localparam int unsigned InDataW = 64;
    localparam int unsigned OutDataW = 48;

    localparam logic [CmdW-1:0] CMD_PACKET      = 4'd0;
    localparam logic [CmdW-1:0] CMD_TICK        = 4'd1;
    localparam logic [CmdW-1:0] CMD_MODE_RPT    = 4'd2;
    localparam logic [CmdW-1:0] CMD_CODE_RPT    = 4'd3;
    localparam logic [CmdW-1:0] CMD_CTRL_RPT    = 4'd4;
    localparam logic [CmdW-1:0] CMD_ESTOP       = 4'd5;
    localparam logic [CmdW-1:0] CMD_BROWN_START = 4'd6;
    localparam logic [CmdW-1:0] CMD_BROWN_END   = 4'd7;
    localparam logic [CmdW-1:0] CMD_REQ_DISABLE = 4'd8;
    localparam logic [CmdW-1:0] CMD_REQ_TIME    = 4'd9;

    localparam logic [7:0] PROTOCOL_VERSION = 8'd1;

    localparam logic [CfgIdxW-1:0] CFG_LINK_DISABLE   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_LINK_LOST      = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_STATUS_CLEAR   = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_STATUS_DISABLE = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_SEQ_JUMP       = 3'd4;

    localparam logic [TimeW-1:0] LINK_DISABLE_RESET   = 32'd300000;
    localparam logic [TimeW-1:0] LINK_LOST_RESET      = 32'd1000000;
    localparam logic [TimeW-1:0] STATUS_CLEAR_RESET   = 32'd150000;
    localparam logic [TimeW-1:0] STATUS_DISABLE_RESET = 32'd200000;
    localparam logic [SeqW-1:0]  SEQ_JUMP_RESET       = 16'd10;

    localparam logic [1:0] MODE_TELEOP = 2'd0;
    localparam logic [1:0] MODE_TEST   = 2'd1;
    localparam logic [1:0] MODE_AUTON  = 2'd2;
    localparam logic [1:0] MODE_OTHER  = 2'd3;

    localparam int unsigned HK_DISABLE     = 3;
    localparam int unsigned HK_ESTOP       = 4;
    localparam int unsigned HK_BROWN_START = 5;
    localparam int unsigned HK_BROWN_END   = 6;
    localparam int unsigned HK_RESTART_CODE = 7;
    localparam int unsigned HK_RESTART     = 8;

    localparam logic [StatusW-1:0] ST_DISABLED  = 6'h01;
    localparam logic [StatusW-1:0] ST_TELEOP    = 6'h02;
    localparam logic [StatusW-1:0] ST_HAS_CODE  = 6'h10;
    localparam logic [StatusW-1:0] ST_MAIN_CTRL = 6'h20;
    localparam logic [StatusW-1:0] ST_KEEP_MASK = 6'h30;

    typedef enum logic [3:0] {
        KIND_PACKET,
        KIND_TICK,
        KIND_MODE_RPT,
        KIND_CODE_RPT,
        KIND_CTRL_RPT,
        KIND_ESTOP,
        KIND_BROWN_START,
        KIND_BROWN_END,
        KIND_REQ_DISABLE,
        KIND_REQ_TIME,
        KIND_NONE
    } t_kind;

    typedef struct packed {
        t_kind           kind;
        logic [TimeW-1:0] now_us;
        logic            want_enabled;
        logic [1:0]      mode_code;
        logic            want_estop;
        logic            field_attached;
        logic            stop_link;
        logic            restart_code_req;
        logic            restart_robot_req;
        logic [SeqW-1:0] packet_sequence;
    } t_item;

    typedef struct packed {
        logic               is_enabled;
        logic [1:0]         run_mode;
        logic               estop_latched;
        logic               brownout_active;
        logic               field_attached_out;
        logic               stop_link_out;
        logic [StatusW-1:0] robot_status;
        logic [1:0]         request_bits;
        logic [HookW-1:0]   hooks_fired;
        logic               send_reply;
        logic [SeqW-1:0]    reply_sequence;
        logic               link_up;
    } t_result;

    typedef struct packed {
        logic       we;
        logic [CfgIdxW-1:0] index;
        logic [CfgDataW-1:0] data;
    } t_cfg_write;

endpackage

`default_nettype wire

>>> src/resc_front.sv
// Front end: unpacks an input transaction and classifies its command.
// Depends on resc_pkg.
`default_nettype none

module resc_front (
    input  wire logic [resc_pkg::CmdW-1:0]    i_command,
    input  wire logic [resc_pkg::InDataW-1:0] i_data,
    output resc_pkg::t_item                   o_item
);

    logic [7:0] w_version;

    assign w_version = i_data[39:32];

    always_comb begin
        o_item.now_us            = i_data[31:0];
        o_item.want_enabled      = i_data[40];
        o_item.mode_code         = i_data[42:41];
        o_item.want_estop        = i_data[43];
        o_item.field_attached    = i_data[44];
        o_item.stop_link         = i_data[45];
        o_item.restart_code_req  = i_data[46];
        o_item.restart_robot_req = i_data[47];
        o_item.packet_sequence   = i_data[63:48];
        unique case (i_command)
            resc_pkg::CMD_PACKET: begin
                // A packet of the wrong version only runs the watchdogs.
                o_item.kind = (w_version == resc_pkg::PROTOCOL_VERSION) ?
                              resc_pkg::KIND_PACKET : resc_pkg::KIND_TICK;
            end
            resc_pkg::CMD_TICK:        o_item.kind = resc_pkg::KIND_TICK;
            resc_pkg::CMD_MODE_RPT:    o_item.kind = resc_pkg::KIND_MODE_RPT;
            resc_pkg::CMD_CODE_RPT:    o_item.kind = resc_pkg::KIND_CODE_RPT;
            resc_pkg::CMD_CTRL_RPT:    o_item.kind = resc_pkg::KIND_CTRL_RPT;
            resc_pkg::CMD_ESTOP:       o_item.kind = resc_pkg::KIND_ESTOP;
            resc_pkg::CMD_BROWN_START: o_item.kind = resc_pkg::KIND_BROWN_START;
            resc_pkg::CMD_BROWN_END:   o_item.kind = resc_pkg::KIND_BROWN_END;
            resc_pkg::CMD_REQ_DISABLE: o_item.kind = resc_pkg::KIND_REQ_DISABLE;
            resc_pkg::CMD_REQ_TIME:    o_item.kind = resc_pkg::KIND_REQ_TIME;
            default:                   o_item.kind = resc_pkg::KIND_NONE;
        endcase
    end

endmodule

`default_nettype wire

>>> src/resc_queue.sv
// Two-entry queue of classified items between the front and the back end.
// Depends on resc_pkg.
`default_nettype none

module resc_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire resc_pkg::t_item i_item,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output resc_pkg::t_item      o_item
);

    resc_pkg::t_item r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            n_wr_ptr;
    logic            n_rd_ptr;
    logic [1:0]      n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

    a_pointers_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

>>> src/resc_back.sv
// Back end: holds the controller state and configuration registers and carries out one queued
// item per cycle unless an unread result stalls it, and registers its result. Depends on resc_pkg.
`default_nettype none

module resc_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire resc_pkg::t_cfg_write i_cfg,
    input  wire logic                 i_valid,
    input  wire resc_pkg::t_item      i_item,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output resc_pkg::t_result         o_result
);

    logic [resc_pkg::TimeW-1:0] r_link_disable_to;
    logic [resc_pkg::TimeW-1:0] r_link_lost_to;
    logic [resc_pkg::TimeW-1:0] r_status_clear_to;
    logic [resc_pkg::TimeW-1:0] r_status_disable_to;
    logic [resc_pkg::SeqW-1:0]  r_seq_jump;

    logic                         r_enabled;
    logic [1:0]                   r_mode;
    logic                         r_estop;
    logic                         r_brown;
    logic                         r_fms;
    logic                         r_stop;
    logic [resc_pkg::StatusW-1:0] r_status;
    logic [1:0]                   r_req;
    logic [resc_pkg::TimeW-1:0]   r_pkt_time;
    logic [resc_pkg::TimeW-1:0]   r_stat_time;
    logic [resc_pkg::SeqW-1:0]    r_last_seq;
    logic                         r_link;

    logic                         n_enabled;
    logic [1:0]                   n_mode;
    logic                         n_estop;
    logic                         n_brown;
    logic                         n_fms;
    logic                         n_stop;
    logic [resc_pkg::StatusW-1:0] n_status;
    logic [1:0]                   n_req;
    logic [resc_pkg::TimeW-1:0]   n_pkt_time;
    logic [resc_pkg::TimeW-1:0]   n_stat_time;
    logic [resc_pkg::SeqW-1:0]    n_last_seq;
    logic                         n_link;
    logic [resc_pkg::HookW-1:0]   n_hooks;
    logic                         n_reply;
    logic [resc_pkg::SeqW-1:0]    n_rseq;

    logic                         r_out_valid;
    resc_pkg::t_result            r_result;

    assign o_pop       = i_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    always_comb begin
        logic [resc_pkg::TimeW-1:0] v_dp;
        logic [resc_pkg::TimeW-1:0] v_ds;
        logic signed [resc_pkg::SeqW:0] v_diff;
        logic [resc_pkg::SeqW:0]    v_next_seq;
        logic                       v_watch;

        n_enabled   = r_enabled;
        n_mode      = r_mode;
        n_estop     = r_estop;
        n_brown     = r_brown;
        n_fms       = r_fms;
        n_stop      = r_stop;
        n_status    = r_status;
        n_req       = r_req;
        n_pkt_time  = r_pkt_time;
        n_stat_time = r_stat_time;
        n_last_seq  = r_last_seq;
        n_link      = r_link;
        n_hooks     = '0;
        n_reply     = 1'b0;
        n_rseq      = '0;
        v_watch     = 1'b0;
        v_next_seq  = {1'b0, r_last_seq} + 17'd1;
        v_diff      = $signed({1'b0, i_item.packet_sequence}) - $signed({1'b0, r_last_seq});

        unique case (i_item.kind)
            resc_pkg::KIND_PACKET: begin
                v_watch = 1'b1;
                n_hooks[resc_pkg::HK_RESTART_CODE] = i_item.restart_code_req;
                n_hooks[resc_pkg::HK_RESTART]      = i_item.restart_robot_req;
                if (i_item.want_enabled != r_enabled) begin
                    if (i_item.want_estop || r_estop ||
                        (i_item.want_enabled && !r_brown &&
                         i_item.mode_code == resc_pkg::MODE_OTHER)) begin
                        if (!r_estop) begin
                            n_enabled = 1'b0;
                            n_estop   = 1'b1;
                            n_hooks[resc_pkg::HK_ESTOP] = 1'b1;
                        end
                    end else if (r_brown) begin
                        n_enabled = r_enabled;
                    end else if (!i_item.want_enabled) begin
                        // Here the robot is enabled and not estopped.
                        n_enabled = 1'b0;
                        n_mode    = resc_pkg::MODE_TELEOP;
                        n_hooks[resc_pkg::HK_DISABLE] = 1'b1;
                    end else begin
                        n_enabled = 1'b1;
                        n_mode    = i_item.mode_code;
                        n_hooks[{2'b00, i_item.mode_code}] = 1'b1;
                    end
                end
                if (i_item.want_estop) begin
                    n_estop = 1'b1;
                end
                if (n_estop) begin
                    n_enabled = 1'b0;
                end
                n_fms  = i_item.field_attached;
                n_stop = i_item.stop_link;
                if (v_next_seq >= {1'b0, i_item.packet_sequence} ||
                    v_diff > $signed({1'b0, r_seq_jump})) begin
                    n_last_seq = i_item.packet_sequence;
                    n_reply    = 1'b1;
                    n_rseq     = i_item.packet_sequence;
                end
                n_pkt_time = i_item.now_us;
                n_link     = 1'b1;
            end
            resc_pkg::KIND_TICK: begin
                v_watch = 1'b1;
            end
            resc_pkg::KIND_MODE_RPT: begin
                n_status = r_status & resc_pkg::ST_KEEP_MASK;
                if (i_item.mode_code == resc_pkg::MODE_OTHER) begin
                    n_status = n_status | resc_pkg::ST_DISABLED;
                end else begin
                    n_status = n_status | (resc_pkg::ST_TELEOP << i_item.mode_code);
                end
                n_stat_time = i_item.now_us;
            end
            resc_pkg::KIND_CODE_RPT: begin
                n_status    = r_status | resc_pkg::ST_HAS_CODE;
                n_stat_time = i_item.now_us;
            end
            resc_pkg::KIND_CTRL_RPT: begin
                n_status    = r_status | resc_pkg::ST_MAIN_CTRL;
                n_stat_time = i_item.now_us;
            end
            resc_pkg::KIND_ESTOP: begin
                if (!r_estop) begin
                    n_enabled = 1'b0;
                    n_estop   = 1'b1;
                    n_hooks[resc_pkg::HK_ESTOP] = 1'b1;
                end
            end
            resc_pkg::KIND_BROWN_START: begin
                if (!r_brown) begin
                    n_brown = 1'b1;
                    n_hooks[resc_pkg::HK_BROWN_START] = 1'b1;
                end
            end
            resc_pkg::KIND_BROWN_END: begin
                if (r_brown) begin
                    n_brown = 1'b0;
                    n_hooks[resc_pkg::HK_BROWN_END] = 1'b1;
                end
            end
            resc_pkg::KIND_REQ_DISABLE: n_req = r_req | 2'b01;
            resc_pkg::KIND_REQ_TIME:    n_req = r_req | 2'b10;
            default: begin
                n_req = r_req;
            end
        endcase

        v_dp = i_item.now_us - n_pkt_time;
        v_ds = i_item.now_us - n_stat_time;
        if (v_watch) begin
            if ((v_dp > r_link_disable_to || v_ds > r_status_disable_to) &&
                n_enabled && !n_estop) begin
                n_enabled = 1'b0;
                n_mode    = resc_pkg::MODE_TELEOP;
                n_hooks[resc_pkg::HK_DISABLE] = 1'b1;
            end
            if (v_dp > r_link_lost_to) begin
                n_link = 1'b0;
            end
            if (v_ds > r_status_clear_to) begin
                n_status = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_disable_to   <= resc_pkg::LINK_DISABLE_RESET;
            r_link_lost_to      <= resc_pkg::LINK_LOST_RESET;
            r_status_clear_to   <= resc_pkg::STATUS_CLEAR_RESET;
            r_status_disable_to <= resc_pkg::STATUS_DISABLE_RESET;
            r_seq_jump          <= resc_pkg::SEQ_JUMP_RESET;
        end else if (i_cfg.we) begin
            unique case (i_cfg.index)
                resc_pkg::CFG_LINK_DISABLE:   r_link_disable_to   <= i_cfg.data;
                resc_pkg::CFG_LINK_LOST:      r_link_lost_to      <= i_cfg.data;
                resc_pkg::CFG_STATUS_CLEAR:   r_status_clear_to   <= i_cfg.data;
                resc_pkg::CFG_STATUS_DISABLE: r_status_disable_to <= i_cfg.data;
                resc_pkg::CFG_SEQ_JUMP:       r_seq_jump <= i_cfg.data[resc_pkg::SeqW-1:0];
                default: begin
                    r_seq_jump <= r_seq_jump;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b0;
            r_mode      <= resc_pkg::MODE_TELEOP;
            r_estop     <= 1'b0;
            r_brown     <= 1'b0;
            r_fms       <= 1'b0;
            r_stop      <= 1'b0;
            r_status    <= '0;
            r_req       <= '0;
            r_pkt_time  <= '0;
            r_stat_time <= '0;
            r_last_seq  <= '0;
            r_link      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_enabled   <= n_enabled;
                r_mode      <= n_mode;
                r_estop     <= n_estop;
                r_brown     <= n_brown;
                r_fms       <= n_fms;
                r_stop      <= n_stop;
                r_status    <= n_status;
                r_req       <= n_req;
                r_pkt_time  <= n_pkt_time;
                r_stat_time <= n_stat_time;
                r_last_seq  <= n_last_seq;
                r_link      <= n_link;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result.is_enabled         <= n_enabled;
            r_result.run_mode           <= n_mode;
            r_result.estop_latched      <= n_estop;
            r_result.brownout_active    <= n_brown;
            r_result.field_attached_out <= n_fms;
            r_result.stop_link_out      <= n_stop;
            r_result.robot_status       <= n_status;
            r_result.request_bits       <= n_req;
            r_result.hooks_fired        <= n_hooks;
            r_result.send_reply         <= n_reply;
            r_result.reply_sequence     <= n_rseq;
            r_result.link_up            <= n_link;
        end
    end

    a_estop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_estop |=> r_estop)
        else $error("latched estop cleared");

    a_estop_disables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_estop && r_enabled))
        else $error("robot enabled while estopped");

    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != resc_pkg::MODE_OTHER)
        else $error("run mode holds the invalid code");

    a_brown_holds_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && r_brown && i_item.kind == resc_pkg::KIND_PACKET &&
         !i_item.want_estop && !r_estop && !r_enabled) |=> !r_enabled)
        else $error("robot enabled during brownout");

endmodule

`default_nettype wire

>>> src/robot_enable_safety_controller.sv
// Top level of the robot enable and emergency-stop controller: front end,
// item queue and back end. Depends on resc_pkg, resc_front, resc_queue, resc_back.
//
//   Channel   Direction  Handshake                     Payload
//   s_axis    in         s_axis_tvalid/s_axis_tready   tuser command, tdata event fields
//   m_axis    out        m_axis_tvalid/m_axis_tready   tdata state, hooks, reply
//   cfg       in         i_cfg_we                      i_cfg_index, i_cfg_wdata
//
// One item per cycle unless a held result stalls the back end; a result appears in the
// cycle after the item enters the back end, which executes it against its state registers.
// A two-entry queue separates input acceptance from the back end, and an output
// register holds a result while m_axis_tready is low.
// Reset is synchronous and active low; it restores the register defaults.
`default_nettype none

module robot_enable_safety_controller (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata, low bit up: now_us[31:0], protocol_version[39:32], want_enabled[40],
    // mode_code[42:41], want_estop[43], field_attached[44], stop_link[45],
    // restart_code_req[46], restart_robot_req[47], packet_sequence[63:48]
    input  wire logic [resc_pkg::InDataW-1:0]     s_axis_tdata,
    // tuser: command[3:0]
    input  wire logic [resc_pkg::CmdW-1:0]        s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // tdata, low bit up: is_enabled[0], run_mode[2:1], estop_latched[3],
    // brownout_active[4], field_attached_out[5], stop_link_out[6],
    // robot_status[12:7], request_bits[14:13], hooks_fired[23:15],
    // send_reply[24], reply_sequence[40:25], link_up[41], zeros[47:42]
    output logic [resc_pkg::OutDataW-1:0]         m_axis_tdata,
    input  wire logic                             i_cfg_we,
    input  wire logic [resc_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  wire logic [resc_pkg::CfgDataW-1:0]    i_cfg_wdata
);

    resc_pkg::t_item      w_front_item;
    resc_pkg::t_item      w_queue_item;
    resc_pkg::t_result    w_result;
    resc_pkg::t_cfg_write w_cfg;
    logic                 w_full;
    logic                 w_push;
    logic                 w_pop;
    logic                 w_queue_valid;

    assign s_axis_tready = !w_full;
    assign w_push        = s_axis_tvalid && !w_full;
    assign w_cfg.we      = i_cfg_we;
    assign w_cfg.index   = i_cfg_index;
    assign w_cfg.data    = i_cfg_wdata;

    resc_front u_front (
        .i_command (s_axis_tuser),
        .i_data    (s_axis_tdata),
        .o_item    (w_front_item)
    );

    resc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_queue_valid),
        .o_item  (w_queue_item)
    );

    resc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (w_queue_valid),
        .i_item      (w_queue_item),
        .o_pop       (w_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_result    (w_result)
    );

    assign m_axis_tdata = {6'd0,
                           w_result.link_up,
                           w_result.reply_sequence,
                           w_result.send_reply,
                           w_result.hooks_fired,
                           w_result.request_bits,
                           w_result.robot_status,
                           w_result.stop_link_out,
                           w_result.field_attached_out,
                           w_result.brownout_active,
                           w_result.estop_latched,
                           w_result.run_mode,
                           w_result.is_enabled};

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for robot_enable_safety_controller: drives event transactions,
// predicts each result with an in-bench model of the enable and estop logic, and checks them.
// Depends on resc_pkg and the RTL in src.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import resc_pkg::*;

    localparam int unsigned IdleLimit = 2000;
    localparam int unsigned MaxIdle = 18;
    localparam logic [CmdW-1:0] CMD_UNUSED_LAST = 4'hF;
    localparam int unsigned REQ_DISABLE_BIT = 0;
    localparam int unsigned REQ_TIME_BIT = 1;

    typedef struct packed {
        logic [CmdW-1:0]  cmd;
        logic [TimeW-1:0] stamp;
        logic [7:0]       ver;
        logic             wen;
        logic [1:0]       mode;
        logic             westop;
        logic             fms;
        logic             stp;
        logic             rcode;
        logic             rrobot;
        logic [SeqW-1:0]  seq;
    } t_controller_event;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata = '0;
    logic [CmdW-1:0]     s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;
    logic                i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgDataW-1:0] i_cfg_wdata = '0;

    robot_enable_safety_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // Model of the controller registers and state.
    logic [TimeW-1:0] link_disable_us = LINK_DISABLE_RESET;
    logic [TimeW-1:0] link_lost_us = LINK_LOST_RESET;
    logic [TimeW-1:0] status_clear_us = STATUS_CLEAR_RESET;
    logic [TimeW-1:0] status_disable_us = STATUS_DISABLE_RESET;
    logic [SeqW-1:0]  seq_jump_limit = SEQ_JUMP_RESET;

    logic               ctl_enabled = 1'b0;
    logic [1:0]         ctl_mode = MODE_TELEOP;
    logic               ctl_estop = 1'b0;
    logic               ctl_brown = 1'b0;
    logic               ctl_fms = 1'b0;
    logic               ctl_stop = 1'b0;
    logic [StatusW-1:0] robot_status_bits = '0;
    logic [1:0]         sticky_requests = '0;
    logic [TimeW-1:0]   last_packet_us = '0;
    logic [TimeW-1:0]   last_report_us = '0;
    logic [SeqW-1:0]    last_seq = '0;
    logic               link_flag = 1'b0;

    t_controller_event pending_events[$];
    t_result           expected_results[$];
    t_controller_event event_on_bus;
    t_result           observed;
    t_result           oldest_expected;
    int unsigned       events_sent = 0;
    int unsigned       events_accepted = 0;
    int unsigned       send_gap = 0;
    int unsigned       receive_stall = 0;
    int unsigned       idle_cycles = 0;
    int unsigned       failures = 0;
    bit                steady_flow = 1'b0;
    logic [TimeW-1:0]  clock_us = '0;
    logic [SeqW-1:0]   seq_count = '0;

    function automatic void drop_enable(inout logic [HookW-1:0] hooks);
        if (ctl_enabled && !ctl_estop) begin
            ctl_enabled = 1'b0;
            ctl_mode = MODE_TELEOP;
            hooks[HK_DISABLE] = 1'b1;
        end
    endfunction

    function automatic void latch_estop(inout logic [HookW-1:0] hooks);
        if (!ctl_estop) begin
            ctl_enabled = 1'b0;
            ctl_estop = 1'b1;
            hooks[HK_ESTOP] = 1'b1;
        end
    endfunction

    function automatic void run_watchdogs(input logic [TimeW-1:0] stamp,
                                          inout logic [HookW-1:0] hooks);
        logic [TimeW-1:0] since_packet;
        logic [TimeW-1:0] since_report;
        since_packet = stamp - last_packet_us;
        since_report = stamp - last_report_us;
        if (since_packet > link_disable_us) drop_enable(hooks);
        if (since_packet > link_lost_us) link_flag = 1'b0;
        if (since_report > status_clear_us) robot_status_bits = '0;
        if (since_report > status_disable_us) drop_enable(hooks);
    endfunction

    function automatic t_result next_controller_result(input t_controller_event ev);
        logic [HookW-1:0] hooks;
        int               seq_step;
        t_result          res;
        hooks = '0;
        res = '0;
        case (ev.cmd)
            CMD_PACKET: begin
                if (ev.ver == PROTOCOL_VERSION) begin
                    hooks[HK_RESTART_CODE] = ev.rcode;
                    hooks[HK_RESTART] = ev.rrobot;
                    if (ev.wen != ctl_enabled) begin
                        if (ev.westop || ctl_estop) begin
                            latch_estop(hooks);
                        end else if (ctl_brown) begin
                            // Brownout holds the current mode.
                        end else if (!ev.wen) begin
                            drop_enable(hooks);
                        end else if (ev.mode == MODE_OTHER) begin
                            latch_estop(hooks);
                        end else begin
                            ctl_enabled = 1'b1;
                            ctl_mode = ev.mode;
                            hooks[{2'b00, ev.mode}] = 1'b1;
                        end
                    end
                    if (ev.westop) ctl_estop = 1'b1;
                    if (ctl_estop) ctl_enabled = 1'b0;
                    ctl_fms = ev.fms;
                    ctl_stop = ev.stp;
                    seq_step = int'(ev.seq) - int'(last_seq);
                    if ({1'b0, last_seq} + 17'd1 >= {1'b0, ev.seq}
                            || seq_step > int'(seq_jump_limit)) begin
                        last_seq = ev.seq;
                        res.send_reply = 1'b1;
                        res.reply_sequence = ev.seq;
                    end
                    last_packet_us = ev.stamp;
                    link_flag = 1'b1;
                end
                run_watchdogs(ev.stamp, hooks);
            end
            CMD_TICK: run_watchdogs(ev.stamp, hooks);
            CMD_MODE_RPT: begin
                robot_status_bits &= ST_KEEP_MASK;
                if (ev.mode == MODE_OTHER) robot_status_bits |= ST_DISABLED;
                else robot_status_bits |= ST_TELEOP << ev.mode;
                last_report_us = ev.stamp;
            end
            CMD_CODE_RPT: begin
                robot_status_bits |= ST_HAS_CODE;
                last_report_us = ev.stamp;
            end
            CMD_CTRL_RPT: begin
                robot_status_bits |= ST_MAIN_CTRL;
                last_report_us = ev.stamp;
            end
            CMD_ESTOP: latch_estop(hooks);
            CMD_BROWN_START: begin
                if (!ctl_brown) begin
                    ctl_brown = 1'b1;
                    hooks[HK_BROWN_START] = 1'b1;
                end
            end
            CMD_BROWN_END: begin
                if (ctl_brown) begin
                    ctl_brown = 1'b0;
                    hooks[HK_BROWN_END] = 1'b1;
                end
            end
            CMD_REQ_DISABLE: sticky_requests[REQ_DISABLE_BIT] = 1'b1;
            CMD_REQ_TIME: sticky_requests[REQ_TIME_BIT] = 1'b1;
            default: ;
        endcase
        res.is_enabled = ctl_enabled;
        res.run_mode = ctl_mode;
        res.estop_latched = ctl_estop;
        res.brownout_active = ctl_brown;
        res.field_attached_out = ctl_fms;
        res.stop_link_out = ctl_stop;
        res.robot_status = robot_status_bits;
        res.request_bits = sticky_requests;
        res.hooks_fired = hooks;
        res.link_up = link_flag;
        return res;
    endfunction

    function automatic int unsigned draw_idle();
        if (steady_flow) return 0;
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MaxIdle);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(next_controller_result(event_on_bus));
                events_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_events.size() > 0) begin
                    event_on_bus = pending_events.pop_front();
                    s_axis_tdata <= {event_on_bus.seq, event_on_bus.rrobot, event_on_bus.rcode,
                                     event_on_bus.stp, event_on_bus.fms, event_on_bus.westop,
                                     event_on_bus.mode, event_on_bus.wen, event_on_bus.ver,
                                     event_on_bus.stamp};
                    s_axis_tuser <= event_on_bus.cmd;
                    s_axis_tvalid <= 1'b1;
                    events_sent++;
                    send_gap = draw_idle();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                observed.is_enabled = m_axis_tdata[0];
                observed.run_mode = m_axis_tdata[2:1];
                observed.estop_latched = m_axis_tdata[3];
                observed.brownout_active = m_axis_tdata[4];
                observed.field_attached_out = m_axis_tdata[5];
                observed.stop_link_out = m_axis_tdata[6];
                observed.robot_status = m_axis_tdata[12:7];
                observed.request_bits = m_axis_tdata[14:13];
                observed.hooks_fired = m_axis_tdata[23:15];
                observed.send_reply = m_axis_tdata[24];
                observed.reply_sequence = m_axis_tdata[40:25];
                observed.link_up = m_axis_tdata[41];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_axis_tdata);
                    failures++;
                end else begin
                    oldest_expected = expected_results.pop_front();
                    check_field("is_enabled", oldest_expected.is_enabled, observed.is_enabled);
                    check_field("run_mode", oldest_expected.run_mode, observed.run_mode);
                    check_field("estop_latched", oldest_expected.estop_latched,
                                observed.estop_latched);
                    check_field("brownout_active", oldest_expected.brownout_active,
                                observed.brownout_active);
                    check_field("field_attached_out", oldest_expected.field_attached_out,
                                observed.field_attached_out);
                    check_field("stop_link_out", oldest_expected.stop_link_out,
                                observed.stop_link_out);
                    check_field("robot_status", oldest_expected.robot_status,
                                observed.robot_status);
                    check_field("request_bits", oldest_expected.request_bits,
                                observed.request_bits);
                    check_field("hooks_fired", oldest_expected.hooks_fired,
                                observed.hooks_fired);
                    check_field("send_reply", oldest_expected.send_reply, observed.send_reply);
                    check_field("reply_sequence", oldest_expected.reply_sequence,
                                observed.reply_sequence);
                    check_field("link_up", oldest_expected.link_up, observed.link_up);
                end
                receive_stall = draw_idle();
            end
            if (receive_stall > 0) begin
                receive_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || i_cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
                $display("%0t: no transaction for %0d cycles", $time, IdleLimit);
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    task automatic queue_event(input logic [CmdW-1:0] cmd, input logic [TimeW-1:0] stamp,
                               input logic [7:0] ver, input logic wen, input logic [1:0] mode,
                               input logic westop, input logic fms, input logic stp,
                               input logic rcode, input logic rrobot,
                               input logic [SeqW-1:0] seq);
        pending_events.push_back({cmd, stamp, ver, wen, mode, westop, fms, stp, rcode,
                                  rrobot, seq});
    endtask

    task automatic queue_random_event(input bit estop_allowed);
        t_controller_event ev;
        int unsigned       pick;
        ev.stamp = '0;
        ev.ver = 8'($urandom);
        ev.wen = 1'($urandom);
        ev.mode = 2'($urandom);
        ev.westop = 1'($urandom);
        ev.fms = 1'($urandom);
        ev.stp = 1'($urandom);
        ev.rcode = 1'($urandom);
        ev.rrobot = 1'($urandom);
        ev.seq = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 85) clock_us += $urandom_range(0, 30000);
        else if (pick < 97) clock_us += $urandom_range(100000, 1500000);
        else clock_us = $urandom;
        ev.stamp = clock_us;
        pick = $urandom_range(0, 99);
        if (pick < 45) ev.cmd = CMD_PACKET;
        else if (pick < 55) ev.cmd = CMD_TICK;
        else if (pick < 68) ev.cmd = CMD_MODE_RPT;
        else if (pick < 73) ev.cmd = CMD_CODE_RPT;
        else if (pick < 78) ev.cmd = CMD_CTRL_RPT;
        else if (pick < 83) ev.cmd = CMD_BROWN_START;
        else if (pick < 88) ev.cmd = CMD_BROWN_END;
        else if (pick < 91) ev.cmd = CMD_REQ_DISABLE;
        else if (pick < 94) ev.cmd = CMD_REQ_TIME;
        else if (pick < 97) ev.cmd = CmdW'($urandom_range(CMD_REQ_TIME + 1, CMD_UNUSED_LAST));
        else ev.cmd = estop_allowed ? CMD_ESTOP : CMD_TICK;
        if (ev.cmd == CMD_PACKET) begin
            if ($urandom_range(0, 9) == 0) begin
                if (!estop_allowed && ev.ver == PROTOCOL_VERSION) ev.ver = ~PROTOCOL_VERSION;
            end else begin
                ev.ver = PROTOCOL_VERSION;
                ev.wen = ($urandom_range(0, 99) < 80);
                if (ev.wen) ev.mode = 2'($urandom_range(MODE_TELEOP, MODE_AUTON));
                if (ev.wen && estop_allowed && $urandom_range(0, 19) == 0) ev.mode = MODE_OTHER;
                ev.westop = estop_allowed && ($urandom_range(0, 29) == 0);
                ev.stp = ($urandom_range(0, 9) == 0);
                ev.rcode = ($urandom_range(0, 19) == 0);
                ev.rrobot = ($urandom_range(0, 19) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 75) seq_count += 1;
                else if (pick < 85) seq_count = seq_count;
                else if (pick < 92) seq_count -= 16'($urandom_range(1, 20));
                else if (pick < 98) seq_count += 16'($urandom_range(2, 40));
                else seq_count = 16'($urandom);
                ev.seq = seq_count;
            end
        end
        pending_events.push_back(ev);
    endtask

    task automatic wait_until_idle();
        while (pending_events.size() != 0 || events_sent != events_accepted
                || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_random_phase(input int unsigned count, input bit estop_allowed);
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 60 == 0) steady_flow = ($urandom_range(0, 2) == 0);
            while (pending_events.size() >= 4) @(negedge i_clk);
            queue_random_event(estop_allowed);
        end
        wait_until_idle();
    endtask

    task automatic write_register(input logic [CfgIdxW-1:0] index,
                                  input logic [CfgDataW-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        case (index)
            CFG_LINK_DISABLE: link_disable_us = value;
            CFG_LINK_LOST: link_lost_us = value;
            CFG_STATUS_CLEAR: status_clear_us = value;
            CFG_STATUS_DISABLE: status_disable_us = value;
            CFG_SEQ_JUMP: seq_jump_limit = value[SeqW-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(input logic [TimeW-1:0] link_disable,
                                  input logic [TimeW-1:0] link_lost,
                                  input logic [TimeW-1:0] status_clear,
                                  input logic [TimeW-1:0] status_disable,
                                  input logic [SeqW-1:0] seq_jump);
        write_register(CFG_LINK_DISABLE, link_disable);
        write_register(CFG_LINK_LOST, link_lost);
        write_register(CFG_STATUS_CLEAR, status_clear);
        write_register(CFG_STATUS_DISABLE, status_disable);
        write_register(CFG_SEQ_JUMP, {16'd0, seq_jump});
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_event(CMD_TICK, 0, 0, 0, MODE_TELEOP, 0, 0, 0, 0, 0, 0);
        queue_event(CMD_MODE_RPT, 1000, 0, 0, MODE_TEST, 0, 0, 0, 0, 0, 0);
        queue_event(CMD_CODE_RPT, 1000, 0, 0, MODE_TELEOP, 0, 0, 0, 0, 0, 0);
        queue_event(CMD_CTRL_RPT, 1000, 0, 0, MODE_TELEOP, 0, 0, 0, 0, 0, 0);
        queue_event(CMD_PACKET, 2000, PROTOCOL_VERSION, 1, MODE_TELEOP, 0, 0, 0, 0, 0, 1);
        queue_event(CMD_PACKET, 3000, PROTOCOL_VERSION, 1, MODE_AUTON, 0, 0, 0, 0, 0, 2);
        queue_event(CMD_PACKET, 4000, PROTOCOL_VERSION, 0, MODE_TELEOP, 0, 0, 0, 0, 0, 3);
        queue_event(CMD_PACKET, 5000, PROTOCOL_VERSION, 1, MODE_AUTON, 0, 0, 0, 0, 0, 4);
        queue_event(CMD_PACKET, 6000, PROTOCOL_VERSION, 0, MODE_TELEOP, 0, 0, 0, 0, 0, 5);
        queue_event(CMD_PACKET, 7000, PROTOCOL_VERSION, 1, MODE_TEST, 0, 1, 1, 1, 1, 20);
        queue_event(CMD_PACKET, 8000, PROTOCOL_VERSION, 1, MODE_TEST, 0, 0, 0, 0, 0, 15);
        queue_event(CMD_PACKET, 9000, PROTOCOL_VERSION, 1, MODE_TEST, 0, 0, 0, 0, 0, 30);
        queue_event(CMD_PACKET, 10000, PROTOCOL_VERSION, 1, MODE_TEST, 0, 0, 0, 0, 0, 35);
        queue_event(CMD_BROWN_START, 11000, 0, 0, MODE_TELEOP, 0, 0, 0, 0, 0, 0);
        queue_event(CMD_BROWN_START, 11000, 0, 0, MODE_TELEOP, 0, 0, 0, 0, 0, 0);
        queue_event(CMD_PACKET, 12000, PROTOCOL_VERSION, 0, MODE_TELEOP, 0, 0, 0, 0, 0, 36);
        queue_event(CMD_BROWN_END, 12000, 0, 0, MODE_TELEOP, 0, 0, 0, 0, 0, 0);
        queue_event(CMD_BROWN_END, 12000, 0, 0, MODE_TELEOP, 0, 0, 0, 0, 0, 0);
        queue_event(CMD_PACKET, 13000, 8'hFF, 0, MODE_OTHER, 1, 1, 1, 1, 1, 16'hFFFF);
        queue_event(CMD_PACKET, 14000, 8'h00, 0, MODE_TELEOP, 0, 0, 0, 0, 0, 0);
        queue_event(CMD_REQ_DISABLE, 14000, 0, 0, MODE_TELEOP, 0, 0, 0, 0, 0, 0);
        queue_event(CMD_REQ_TIME, 14000, 0, 0, MODE_TELEOP, 0, 0, 0, 0, 0, 0);
        queue_event(CMD_UNUSED_LAST, 32'hFFFFFFFF, 8'hFF, 1, MODE_OTHER, 1, 1, 1, 1, 1,
                    16'hFFFF);
        queue_event(CMD_TICK, 314001, 0, 0, MODE_TELEOP, 0, 0, 0, 0, 0, 0);
        queue_event(CMD_TICK, 1214001, 0, 0, MODE_TELEOP, 0, 0, 0, 0, 0, 0);
        queue_event(CMD_MODE_RPT, 1214001, 0, 0, MODE_OTHER, 0, 0, 0, 0, 0, 0);
        wait_until_idle();
        clock_us = 1214001;
        seq_count = 36;

        run_random_phase(250, 1'b0);
        apply_settings(20000, 50000, 10000, 15000, 0);
        run_random_phase(200, 1'b0);
        apply_settings(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
        run_random_phase(150, 1'b0);
        apply_settings(1, 1, 1, 1, 0);
        run_random_phase(100, 1'b0);
        apply_settings($urandom_range(5000, 400000), $urandom_range(5000, 1500000),
                       $urandom_range(5000, 300000), $urandom_range(5000, 300000),
                       16'($urandom_range(0, 64)));

        // Estop stays latched until reset, so its cases run last.
        clock_us += 1000;
        seq_count += 1;
        queue_event(CMD_BROWN_END, clock_us, 0, 0, MODE_TELEOP, 0, 0, 0, 0, 0, 0);
        queue_event(CMD_PACKET, clock_us, PROTOCOL_VERSION, 0, MODE_TELEOP, 0, 0, 0, 0, 0,
                    seq_count);
        seq_count += 1;
        case ($urandom_range(0, 3))
            0: queue_event(CMD_ESTOP, clock_us, 0, 0, MODE_TELEOP, 0, 0, 0, 0, 0, 0);
            1: queue_event(CMD_PACKET, clock_us, PROTOCOL_VERSION, 1, MODE_OTHER, 0, 0, 0, 0,
                           0, seq_count);
            2: queue_event(CMD_PACKET, clock_us, PROTOCOL_VERSION, 1, MODE_TELEOP, 1, 0, 0, 0,
                           0, seq_count);
            default: queue_event(CMD_PACKET, clock_us, PROTOCOL_VERSION, 0, MODE_TELEOP, 1, 0,
                                 0, 0, 0, seq_count);
        endcase
        seq_count += 1;
        queue_event(CMD_PACKET, clock_us, PROTOCOL_VERSION, 0, MODE_TELEOP, 1, 0, 0, 0, 0,
                    seq_count);
        queue_event(CMD_ESTOP, clock_us, 0, 0, MODE_TELEOP, 0, 0, 0, 0, 0, 0);
        seq_count += 1;
        queue_event(CMD_PACKET, clock_us, PROTOCOL_VERSION, 1, MODE_AUTON, 0, 0, 0, 0, 0,
                    seq_count);
        queue_event(CMD_TICK, clock_us, 0, 0, MODE_TELEOP, 0, 0, 0, 0, 0, 0);
        wait_until_idle();
        run_random_phase(150, 1'b1);

        repeat (10) @(negedge i_clk);
        if (failures == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/resc_pkg.sv
src/resc_front.sv
src/resc_queue.sv
src/resc_back.sv
src/robot_enable_safety_controller.sv
test/testbench.sv
